/* hdl/nbam_pkg.sv */
// Shared types, widths and constants of the flash bank address translator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nbam_pkg;

    localparam int BANK_W  = 11;
    localparam int BLOCK_W = 16;
    localparam int PAGE_W  = 16;
    localparam int CH_W    = 4;
    localparam int CHIP_W  = 3;
    localparam int UNIT_W  = 4;
    localparam int ROW_W   = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // reciprocal scale: q = (x * RCP) >> RCP_SHIFT is exact for x < 2048, n <= 31
    localparam int RCP_SHIFT = 16;
    localparam int RCP_W     = 17;

    localparam int MAX_BANKS = 2048;
    localparam logic [BANK_W-1:0] TOP_BANK =
        BANK_W'((MAX_BANKS - 1) < 2047 ? (MAX_BANKS - 1) : 2047);

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT     = 3'd0,
        CFG_UNITS_PER_CHIP    = 3'd1,
        CFG_CHIPS_PER_CHANNEL = 3'd2,
        CFG_PAGE_BITS         = 3'd3,
        CFG_BLOCK_BITS        = 3'd4,
        CFG_UNIT_BITS         = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]       nch;       // effective counts, zero reads as one
        logic [4:0]       nun;
        logic [3:0]       nce;
        logic [RCP_W-1:0] rcp_ch;
        logic [RCP_W-1:0] rcp_un;
        logic [RCP_W-1:0] rcp_ce;
        logic [4:0]       page_bits;
        logic [4:0]       block_bits;
        logic [2:0]       unit_bits;
        logic [5:0]       unit_pos;
        logic [6:0]       slc_pos;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [BANK_W-1:0] bank_in;
        logic [BLOCK_W-1:0] block_in;
        logic [PAGE_W-1:0] page_in;
        logic              slc_in;
        logic [CH_W-1:0]   channel_in;
        logic [CHIP_W-1:0] chip_index_in;
        logic [ROW_W-1:0]  row_in;
    } t_req;

    typedef struct packed {
        logic [CH_W-1:0]    channel_out;
        logic [CHIP_W-1:0]  chip_index_out;
        logic [UNIT_W-1:0]  unit_out;
        logic [ROW_W-1:0]   row_out;
        logic [BANK_W-1:0]  bank_out;
        logic [BLOCK_W-1:0] block_out;
        logic [PAGE_W-1:0]  page_out;
        logic               slc_out;
        logic               range_error;
    } t_rsp;

    function automatic logic [4:0] at_least_one(input logic [4:0] n);
        return (n == 5'd0) ? 5'd1 : n;
    endfunction

    // ceil(2^16 / n), zero treated as one
    function automatic logic [RCP_W-1:0] rcp_of(input logic [4:0] n);
        logic [RCP_W-1:0] r;
        unique case (n)
            5'd0, 5'd1: r = 17'd65536;
            5'd2:  r = 17'd32768;
            5'd3:  r = 17'd21846;
            5'd4:  r = 17'd16384;
            5'd5:  r = 17'd13108;
            5'd6:  r = 17'd10923;
            5'd7:  r = 17'd9363;
            5'd8:  r = 17'd8192;
            5'd9:  r = 17'd7282;
            5'd10: r = 17'd6554;
            5'd11: r = 17'd5958;
            5'd12: r = 17'd5462;
            5'd13: r = 17'd5042;
            5'd14: r = 17'd4682;
            5'd15: r = 17'd4370;
            5'd16: r = 17'd4096;
            5'd17: r = 17'd3856;
            5'd18: r = 17'd3641;
            5'd19: r = 17'd3450;
            5'd20: r = 17'd3277;
            5'd21: r = 17'd3121;
            5'd22: r = 17'd2979;
            5'd23: r = 17'd2850;
            5'd24: r = 17'd2731;
            5'd25: r = 17'd2622;
            5'd26: r = 17'd2521;
            5'd27: r = 17'd2428;
            5'd28: r = 17'd2341;
            5'd29: r = 17'd2260;
            5'd30: r = 17'd2185;
            5'd31: r = 17'd2115;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/nbam_req_if.sv */
// Request channel of the address translator: valid/ready plus request fields.
// Depends on nbam_pkg for field widths.
`default_nettype none

interface nbam_req_if;
    import nbam_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [BANK_W-1:0]   bank_in;
    logic [BLOCK_W-1:0]  block_in;
    logic [PAGE_W-1:0]   page_in;
    logic                slc_in;
    logic [CH_W-1:0]     channel_in;
    logic [CHIP_W-1:0]   chip_index_in;
    logic [ROW_W-1:0]    row_in;

    modport source (
        output valid, kind, bank_in, block_in, page_in, slc_in,
               channel_in, chip_index_in, row_in,
        input  ready
    );

    modport sink (
        input  valid, kind, bank_in, block_in, page_in, slc_in,
               channel_in, chip_index_in, row_in,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/nbam_rsp_if.sv */
// Result channel of the address translator: valid/ready plus result fields.
// Depends on nbam_pkg for field widths.
`default_nettype none

interface nbam_rsp_if;
    import nbam_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_out;
    logic [CHIP_W-1:0]   chip_index_out;
    logic [UNIT_W-1:0]   unit_out;
    logic [ROW_W-1:0]    row_out;
    logic [BANK_W-1:0]   bank_out;
    logic [BLOCK_W-1:0]  block_out;
    logic [PAGE_W-1:0]   page_out;
    logic                slc_out;
    logic                range_error;

    modport source (
        output valid, channel_out, chip_index_out, unit_out, row_out, bank_out,
               block_out, page_out, slc_out, range_error,
        input  ready
    );

    modport sink (
        input  valid, channel_out, chip_index_out, unit_out, row_out, bank_out,
               block_out, page_out, slc_out, range_error,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/nand_bank_address_map_top.sv */
// Top level of the flash bank address translator: five-stage request pipeline.
// Depends on nbam_pkg, nbam_req_if, nbam_rsp_if and nbam_cfg.
//
//   channel   dir  handshake      contents
//   i_req     in   valid/ready    kind, bank/block/page/slc or channel/chip/row
//   o_rsp     out  valid/ready    channel, chip, unit, row, bank, block, page, slc, err
//   i_cfg_*   in   write enable   register index, 5-bit write data
//
// One request per cycle unless a stall holds the pipe; requests pass stages A to E in
// order. Stages A to C each hold one reciprocal multiply (11 x 17 bits), B to D small
// multiply-adds, which set the stage depth. Reset clears the valid bits and loads the
// register defaults. A stall only holds the stages that are full up to the stalled
// output; empty stages keep filling, so no request is lost or repeated.
`default_nettype none

module nand_bank_address_map_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    nbam_req_if.sink                            i_req,
    nbam_rsp_if.source                          o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [nbam_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nbam_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import nbam_pkg::*;

    localparam int NSTG = 5;

    t_cfg cfg;

    nbam_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // ---------------- flow control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_v[NSTG-1] || o_rsp.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    // no request is taken while reset is held
    assign i_req.ready = w_adv[0] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_req.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- stage A: request ----------------
    t_req r_a_req;

    logic [27:0]        w_prod_a;
    logic [ROW_W-1:0]   w_ones;
    logic [ROW_W-1:0]   w_dpage_a, w_dblk_a, w_dunit_a, w_dslc_a;

    assign w_ones   = '1;
    assign w_prod_a = 28'(r_a_req.bank_in) * 28'(cfg.rcp_ch);

    // decode field extraction; shifts of 32 or more read as zero
    assign w_dpage_a = r_a_req.row_in & ~(w_ones << cfg.page_bits);
    assign w_dblk_a  = (r_a_req.row_in >> cfg.page_bits) & ~(w_ones << cfg.block_bits);
    assign w_dunit_a = (r_a_req.row_in >> cfg.unit_pos) & ~(w_ones << cfg.unit_bits);
    assign w_dslc_a  = r_a_req.row_in >> cfg.slc_pos;

    // ---------------- stage B ----------------
    t_req               r_b_req;
    logic [BANK_W-1:0]  r_b_q1;
    logic [PAGE_W-1:0]  r_b_page;
    logic [BLOCK_W-1:0] r_b_block;
    logic [6:0]         r_b_unit;
    logic               r_b_slc;

    logic [15:0] w_qn_b;
    logic [15:0] w_ch_b;
    logic [27:0] w_prod_b;
    logic        w_err_b;
    logic [8:0]  w_t_b;

    assign w_qn_b   = 16'(r_b_q1) * 16'(cfg.nch);
    assign w_ch_b   = 16'(r_b_req.bank_in) - w_qn_b;
    assign w_prod_b = 28'(r_b_q1) * 28'(cfg.rcp_un);
    assign w_err_b  = (5'(r_b_req.channel_in) >= cfg.nch) ||
                      (4'(r_b_req.chip_index_in) >= cfg.nce) ||
                      (r_b_unit >= 7'(cfg.nun));
    assign w_t_b    = 9'(r_b_req.chip_index_in) * 9'(cfg.nun) + 9'(r_b_unit);

    // ---------------- stage C ----------------
    t_req               r_c_req;
    logic [4:0]         r_c_ch;
    logic [BANK_W-1:0]  r_c_q1, r_c_q2;
    logic [PAGE_W-1:0]  r_c_page;
    logic [BLOCK_W-1:0] r_c_block;
    logic [6:0]         r_c_unit;
    logic               r_c_slc;
    logic               r_c_err;
    logic [8:0]         r_c_t;

    logic [15:0] w_qn_c;
    logic [15:0] w_unit_c;
    logic [27:0] w_prod_c;
    logic [13:0] w_bank_c;

    assign w_qn_c   = 16'(r_c_q2) * 16'(cfg.nun);
    assign w_unit_c = 16'(r_c_q1) - w_qn_c;
    assign w_prod_c = 28'(r_c_q2) * 28'(cfg.rcp_ce);
    assign w_bank_c = 14'(r_c_t) * 14'(cfg.nch) + 14'(r_c_req.channel_in);

    // ---------------- stage D ----------------
    t_req               r_d_req;
    logic [4:0]         r_d_ch;
    logic [4:0]         r_d_eunit;
    logic [BANK_W-1:0]  r_d_q2, r_d_q3;
    logic [PAGE_W-1:0]  r_d_page;
    logic [BLOCK_W-1:0] r_d_block;
    logic [6:0]         r_d_unit;
    logic               r_d_slc;
    logic               r_d_err;
    logic [13:0]        r_d_bank;

    logic [15:0] w_qn_d;
    logic [15:0] w_chip_d;
    logic [ROW_W-1:0] w_row_d;
    t_rsp        w_rsp_d;

    assign w_qn_d   = 16'(r_d_q3) * 16'(cfg.nce);
    assign w_chip_d = 16'(r_d_q2) - w_qn_d;

    // page and block go in unmasked; bits pushed past 31 are dropped
    assign w_row_d = ROW_W'(r_d_req.page_in) |
                     (ROW_W'(r_d_req.block_in) << cfg.page_bits) |
                     (ROW_W'(r_d_eunit) << cfg.unit_pos) |
                     (ROW_W'(r_d_req.slc_in) << cfg.slc_pos);

    always_comb begin
        w_rsp_d = '0;
        if (r_d_req.kind == KIND_ENCODE) begin
            w_rsp_d.channel_out    = r_d_ch[CH_W-1:0];
            w_rsp_d.chip_index_out = w_chip_d[CHIP_W-1:0];
            w_rsp_d.unit_out       = r_d_eunit[UNIT_W-1:0];
            w_rsp_d.row_out        = w_row_d;
        end else begin
            w_rsp_d.unit_out    = r_d_unit[UNIT_W-1:0];
            w_rsp_d.bank_out    = (r_d_err || r_d_bank > 14'(TOP_BANK)) ?
                                  TOP_BANK : r_d_bank[BANK_W-1:0];
            w_rsp_d.block_out   = r_d_block;
            w_rsp_d.page_out    = r_d_page;
            w_rsp_d.slc_out     = r_d_slc;
            w_rsp_d.range_error = r_d_err;
        end
    end

    // ---------------- stage E: output register ----------------
    t_rsp r_e_rsp;

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_req <= '{kind: i_req.kind, bank_in: i_req.bank_in,
                         block_in: i_req.block_in, page_in: i_req.page_in,
                         slc_in: i_req.slc_in, channel_in: i_req.channel_in,
                         chip_index_in: i_req.chip_index_in, row_in: i_req.row_in};
        end
        if (w_adv[1]) begin
            r_b_req   <= r_a_req;
            r_b_q1    <= w_prod_a[RCP_SHIFT +: BANK_W];
            r_b_page  <= w_dpage_a[PAGE_W-1:0];
            r_b_block <= w_dblk_a[BLOCK_W-1:0];
            r_b_unit  <= w_dunit_a[6:0];
            r_b_slc   <= w_dslc_a[0];
        end
        if (w_adv[2]) begin
            r_c_req   <= r_b_req;
            r_c_ch    <= w_ch_b[4:0];
            r_c_q1    <= r_b_q1;
            r_c_q2    <= w_prod_b[RCP_SHIFT +: BANK_W];
            r_c_page  <= r_b_page;
            r_c_block <= r_b_block;
            r_c_unit  <= r_b_unit;
            r_c_slc   <= r_b_slc;
            r_c_err   <= w_err_b;
            r_c_t     <= w_t_b;
        end
        if (w_adv[3]) begin
            r_d_req   <= r_c_req;
            r_d_ch    <= r_c_ch;
            r_d_eunit <= w_unit_c[4:0];
            r_d_q2    <= r_c_q2;
            r_d_q3    <= w_prod_c[RCP_SHIFT +: BANK_W];
            r_d_page  <= r_c_page;
            r_d_block <= r_c_block;
            r_d_unit  <= r_c_unit;
            r_d_slc   <= r_c_slc;
            r_d_err   <= r_c_err;
            r_d_bank  <= w_bank_c;
        end
        if (w_adv[4]) begin
            r_e_rsp <= w_rsp_d;
        end
    end

    assign o_rsp.valid          = r_v[NSTG-1];
    assign o_rsp.channel_out    = r_e_rsp.channel_out;
    assign o_rsp.chip_index_out = r_e_rsp.chip_index_out;
    assign o_rsp.unit_out       = r_e_rsp.unit_out;
    assign o_rsp.row_out        = r_e_rsp.row_out;
    assign o_rsp.bank_out       = r_e_rsp.bank_out;
    assign o_rsp.block_out      = r_e_rsp.block_out;
    assign o_rsp.page_out       = r_e_rsp.page_out;
    assign o_rsp.slc_out        = r_e_rsp.slc_out;
    assign o_rsp.range_error    = r_e_rsp.range_error;

endmodule

`default_nettype wire

/* hdl/nbam_cfg.sv */
// Configuration registers plus derived values (reciprocals, field positions).
// Depends on nbam_pkg.
`default_nettype none

module nbam_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [nbam_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nbam_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output nbam_pkg::t_cfg                      o_cfg
);
    import nbam_pkg::*;

    logic [4:0]       r_nch, r_nun;
    logic [3:0]       r_nce;
    logic [RCP_W-1:0] r_rcp_ch, r_rcp_un, r_rcp_ce;
    logic [4:0]       r_page_bits, r_block_bits;
    logic [2:0]       r_unit_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch        <= 5'd1;
            r_nun        <= 5'd1;
            r_nce        <= 4'd1;
            r_rcp_ch     <= rcp_of(5'd1);
            r_rcp_un     <= rcp_of(5'd1);
            r_rcp_ce     <= rcp_of(5'd1);
            r_page_bits  <= 5'd8;
            r_block_bits <= 5'd12;
            r_unit_bits  <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANNEL_COUNT: begin
                    r_nch    <= at_least_one(i_cfg_wdata);
                    r_rcp_ch <= rcp_of(i_cfg_wdata);
                end
                CFG_UNITS_PER_CHIP: begin
                    r_nun    <= at_least_one(i_cfg_wdata);
                    r_rcp_un <= rcp_of(i_cfg_wdata);
                end
                CFG_CHIPS_PER_CHANNEL: begin
                    r_nce    <= 4'(at_least_one({1'b0, i_cfg_wdata[3:0]}));
                    r_rcp_ce <= rcp_of({1'b0, i_cfg_wdata[3:0]});
                end
                CFG_PAGE_BITS:  r_page_bits  <= i_cfg_wdata;
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_wdata;
                CFG_UNIT_BITS:  r_unit_bits  <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg            = '0;
        o_cfg.nch        = r_nch;
        o_cfg.nun        = r_nun;
        o_cfg.nce        = r_nce;
        o_cfg.rcp_ch     = r_rcp_ch;
        o_cfg.rcp_un     = r_rcp_un;
        o_cfg.rcp_ce     = r_rcp_ce;
        o_cfg.page_bits  = r_page_bits;
        o_cfg.block_bits = r_block_bits;
        o_cfg.unit_bits  = r_unit_bits;
        o_cfg.unit_pos   = 6'(r_page_bits) + 6'(r_block_bits);
        o_cfg.slc_pos    = 7'(r_page_bits) + 7'(r_block_bits) + 7'(r_unit_bits);
    end

endmodule

`default_nettype wire

/* test/nbam_map_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the flash bank address translator: mirrors the register writes,
// predicts every accepted request and checks the results in order.
// Depends on nbam_pkg, nbam_req_if and nbam_rsp_if.

module nbam_map_checker
    import nbam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nbam_req_if                   i_req,
    nbam_rsp_if                   i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [4:0] channels;
        logic [4:0] units;
        logic [3:0] chips;
        logic [4:0] page_w;
        logic [4:0] block_w;
        logic [2:0] unit_w;
    } geometry_t;

    localparam geometry_t GEOMETRY_AT_RESET = '{
        channels: 5'd1, units: 5'd1, chips: 4'd1,
        page_w: 5'd8, block_w: 5'd12, unit_w: 3'd2
    };

    geometry_t geo = GEOMETRY_AT_RESET;
    t_rsp      expected_maps[$];
    int        mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic t_rsp translate_request(input t_req r, input geometry_t g);
        t_rsp        res;
        logic [63:0] nch, nun, nce, blk_pos, unit_pos, slc_pos;
        logic [63:0] ch, chip, unit, bank, row, page, block, slc;
        logic        err;
        res = '0;
        // a zero count behaves as one
        nch = (g.channels == 5'd0) ? 64'd1 : 64'(g.channels);
        nun = (g.units == 5'd0) ? 64'd1 : 64'(g.units);
        nce = (g.chips == 4'd0) ? 64'd1 : 64'(g.chips);
        blk_pos  = 64'(g.page_w);
        unit_pos = blk_pos + 64'(g.block_w);
        slc_pos  = unit_pos + 64'(g.unit_w);
        if (r.kind == KIND_ENCODE) begin
            bank = 64'(r.bank_in);
            ch   = bank % nch;
            unit = (bank / nch) % nun;
            chip = (bank / (nun * nch)) % nce;
            // fields go in unmasked; anything past bit 31 falls off
            row  = 64'(r.page_in) | (64'(r.block_in) << blk_pos)
                 | (unit << unit_pos) | (64'(r.slc_in) << slc_pos);
            res.channel_out    = ch[CH_W-1:0];
            res.chip_index_out = chip[CHIP_W-1:0];
            res.unit_out       = unit[UNIT_W-1:0];
            res.row_out        = row[ROW_W-1:0];
        end else begin
            ch    = 64'(r.channel_in);
            chip  = 64'(r.chip_index_in);
            row   = 64'(r.row_in);
            page  = row & ((64'd1 << g.page_w) - 64'd1);
            block = (row >> blk_pos) & ((64'd1 << g.block_w) - 64'd1);
            unit  = (row >> unit_pos) & ((64'd1 << g.unit_w) - 64'd1);
            slc   = (row >> slc_pos) & 64'd1;
            err   = (ch >= nch) || (chip >= nce) || (unit >= nun);
            bank  = chip * nch * nun + unit * nch + ch;
            if (err || bank > 64'(TOP_BANK))
                bank = 64'(TOP_BANK);
            res.unit_out    = unit[UNIT_W-1:0];
            res.bank_out    = bank[BANK_W-1:0];
            res.block_out   = block[BLOCK_W-1:0];
            res.page_out    = page[PAGE_W-1:0];
            res.slc_out     = slc[0];
            res.range_error = err;
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v, got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // valid/ready seen at the falling edge decide the next rising edge
    always @(negedge i_clk) begin
        t_req req;
        t_rsp want;
        if (!i_rst_n) begin
            geo = GEOMETRY_AT_RESET;
            expected_maps.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHANNEL_COUNT:     geo.channels = i_cfg_wdata[4:0];
                    CFG_UNITS_PER_CHIP:    geo.units    = i_cfg_wdata[4:0];
                    CFG_CHIPS_PER_CHANNEL: geo.chips    = i_cfg_wdata[3:0];
                    CFG_PAGE_BITS:         geo.page_w   = i_cfg_wdata[4:0];
                    CFG_BLOCK_BITS:        geo.block_w  = i_cfg_wdata[4:0];
                    CFG_UNIT_BITS:         geo.unit_w   = i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                req.kind          = i_req.kind;
                req.bank_in       = i_req.bank_in;
                req.block_in      = i_req.block_in;
                req.page_in       = i_req.page_in;
                req.slc_in        = i_req.slc_in;
                req.channel_in    = i_req.channel_in;
                req.chip_index_in = i_req.chip_index_in;
                req.row_in        = i_req.row_in;
                expected_maps.push_back(translate_request(req, geo));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_maps.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("channel_out", 32'(want.channel_out), 32'(i_rsp.channel_out));
                    check_field("chip_index_out", 32'(want.chip_index_out),
                                32'(i_rsp.chip_index_out));
                    check_field("unit_out", 32'(want.unit_out), 32'(i_rsp.unit_out));
                    check_field("row_out", want.row_out, i_rsp.row_out);
                    check_field("bank_out", 32'(want.bank_out), 32'(i_rsp.bank_out));
                    check_field("block_out", 32'(want.block_out), 32'(i_rsp.block_out));
                    check_field("page_out", 32'(want.page_out), 32'(i_rsp.page_out));
                    check_field("slc_out", 32'(want.slc_out), 32'(i_rsp.slc_out));
                    check_field("range_error", 32'(want.range_error), 32'(i_rsp.range_error));
                end
            end
        end
        o_outstanding = expected_maps.size();
    end

endmodule

/* test/tb_nand_bank_address_map_top.sv */
`timescale 1ns / 100ps
// Testbench top for the flash bank address translator: clock, reset, register
// setup, request stimulus with bursts and back-pressure, watchdog and verdict.
// Depends on nbam_pkg, nbam_req_if, nbam_rsp_if, the block's top and nbam_map_checker.

module tb_nand_bank_address_map_top;
    import nbam_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RSP_HOLD_CYCLES = 80;
    localparam int PIPE_SETTLE     = 8;
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_REQUESTS  = 120;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;

    // geometry as the block sees it, used to build well-formed requests
    int eff_channels, eff_units, eff_chips, page_w, block_w, unit_w;

    bit rsp_stall_en  = 1'b0;
    bit long_hold_req = 1'b0;

    nbam_req_if req_if();
    nbam_rsp_if rsp_if();

    nand_bank_address_map_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    nbam_map_checker u_map_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: short random stalls, or one long hold-off when asked
    initial begin
        int stall;
        int run;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_req) begin
                stall = RSP_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else if (rsp_stall_en) begin
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            end else begin
                stall = 0;
            end
            run = $urandom_range(1, 12);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    task automatic offer_request(input t_req r);
        req_if.valid         <= 1'b1;
        req_if.kind          <= r.kind;
        req_if.bank_in       <= r.bank_in;
        req_if.block_in      <= r.block_in;
        req_if.page_in       <= r.page_in;
        req_if.slc_in        <= r.slc_in;
        req_if.channel_in    <= r.channel_in;
        req_if.chip_index_in <= r.chip_index_in;
        req_if.row_in        <= r.row_in;
        do @(negedge i_clk); while (!req_if.ready);
        @(posedge i_clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input int value);
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic load_geometry(input int nch, nun, nce, pbits, bbits, ubits);
        cfg_we <= 1'b1;
        put_reg(CFG_CHANNEL_COUNT, nch);
        put_reg(CFG_UNITS_PER_CHIP, nun);
        put_reg(CFG_CHIPS_PER_CHANNEL, nce);
        put_reg(CFG_PAGE_BITS, pbits);
        put_reg(CFG_BLOCK_BITS, bbits);
        put_reg(CFG_UNIT_BITS, ubits);
        cfg_we <= 1'b0;
        eff_channels = ((nch & 31) == 0) ? 1 : (nch & 31);
        eff_units    = ((nun & 31) == 0) ? 1 : (nun & 31);
        eff_chips    = ((nce & 15) == 0) ? 1 : (nce & 15);
        page_w       = pbits & 31;
        block_w      = bbits & 31;
        unit_w       = ubits & 7;
    endtask

    function automatic t_req encode_req(input int bank, block, page, slc);
        t_req r;
        r = '0;
        r.kind     = KIND_ENCODE;
        r.bank_in  = BANK_W'(bank);
        r.block_in = BLOCK_W'(block);
        r.page_in  = PAGE_W'(page);
        r.slc_in   = 1'(slc);
        return r;
    endfunction

    function automatic t_req decode_req(input int ch, chip, input logic [31:0] row);
        t_req r;
        r = '0;
        r.kind          = KIND_DECODE;
        r.channel_in    = CH_W'(ch);
        r.chip_index_in = CHIP_W'(chip);
        r.row_in        = row;
        return r;
    endfunction

    function automatic t_req make_request(input bit well_formed);
        t_req        r;
        logic [63:0] built;
        int          ch_cap, chip_cap, unit_cap, unit_pos, slc_pos;
        r.kind          = $urandom_range(0, 1) ? KIND_DECODE : KIND_ENCODE;
        r.bank_in       = BANK_W'($urandom);
        r.block_in      = BLOCK_W'($urandom);
        r.page_in       = PAGE_W'($urandom);
        r.slc_in        = 1'($urandom);
        r.channel_in    = CH_W'($urandom);
        r.chip_index_in = CHIP_W'($urandom);
        r.row_in        = $urandom;
        if (r.kind == KIND_ENCODE) begin
            if ($urandom_range(0, 3) == 0)
                r.bank_in = BANK_W'($urandom_range(0, 63));
            if (well_formed) begin
                r.page_in  &= PAGE_W'((64'd1 << page_w) - 64'd1);
                r.block_in &= BLOCK_W'((64'd1 << block_w) - 64'd1);
            end
        end else if (well_formed) begin
            ch_cap   = (eff_channels > 16) ? 15 : eff_channels - 1;
            chip_cap = (eff_chips > 8) ? 7 : eff_chips - 1;
            unit_cap = eff_units - 1;
            if (unit_cap > (1 << unit_w) - 1)
                unit_cap = (1 << unit_w) - 1;
            unit_pos = page_w + block_w;
            slc_pos  = unit_pos + unit_w;
            r.channel_in    = CH_W'($urandom_range(0, ch_cap));
            r.chip_index_in = CHIP_W'($urandom_range(0, chip_cap));
            // in-range fields, random junk above the slc bit
            built = (64'($urandom) & ((64'd1 << page_w) - 64'd1))
                  | ((64'($urandom) & ((64'd1 << block_w) - 64'd1)) << page_w)
                  | (64'($urandom_range(0, unit_cap)) << unit_pos)
                  | (64'($urandom_range(0, 1)) << slc_pos)
                  | (64'($urandom) << (slc_pos + 1));
            r.row_in = built[31:0];
        end
        return r;
    endfunction

    initial begin
        int  sent;
        int  burst;
        int  gap;
        bit  gaps_on;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_wdata            <= '0;
        req_if.valid         <= 1'b0;
        req_if.kind          <= KIND_ENCODE;
        req_if.bank_in       <= '0;
        req_if.block_in      <= '0;
        req_if.page_in       <= '0;
        req_if.slc_in        <= 1'b0;
        req_if.channel_in    <= '0;
        req_if.chip_index_in <= '0;
        req_if.row_in        <= '0;
        eff_channels = 1;
        eff_units    = 1;
        eff_chips    = 1;
        page_w       = 8;
        block_w      = 12;
        unit_w       = 2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset
        offer_request(encode_req(0, 0, 0, 0));
        offer_request(encode_req(2047, 16'hFFFF, 16'hFFFF, 1));
        offer_request(decode_req(0, 0, 32'h0));
        offer_request(decode_req(0, 0, 32'hFFFF_FFFF));
        offer_request(decode_req(15, 0, 32'h0));
        offer_request(decode_req(0, 7, 32'h0));
        settle();

        // largest legal geometry: unit lands on bit 32, slc beyond it
        load_geometry(16, 16, 8, 16, 16, 4);
        offer_request(encode_req(2047, 16'hFFFF, 16'hFFFF, 1));
        offer_request(decode_req(15, 7, 32'hFFFF_FFFF));
        offer_request(decode_req(15, 7, 32'h0));
        settle();

        // zero counts and zero-width fields
        load_geometry(0, 0, 0, 0, 0, 0);
        offer_request(encode_req(1234, 16'hABCD, 16'h1357, 1));
        offer_request(decode_req(0, 0, 32'hFFFF_FFFF));
        offer_request(decode_req(1, 0, 32'h0));
        settle();

        // all-ones register data; the rebuilt bank overflows and saturates
        load_geometry(31, 31, 31, 31, 31, 31);
        offer_request(encode_req(2047, 16'hFFFF, 16'hFFFF, 1));
        offer_request(decode_req(15, 7, 32'h0));
        offer_request(decode_req(15, 7, 32'hFFFF_FFFF));
        offer_request(encode_req(1000, 16'h5A5A, 16'hA5A5, 0));
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_geometry(1, 1, 1, 0, 0, 0);
                1: load_geometry(16, 16, 8, 16, 16, 4);
                2: load_geometry(4, 2, 4, 8, 12, 2);
                default: load_geometry(
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4));
            endcase
            rsp_stall_en = (phase % 3 != 0);
            gaps_on      = (phase % 4 != 1) && (phase != 2);
            // back-to-back requests against a long result hold-off fill the pipe
            if (phase == 2)
                long_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < PHASE_REQUESTS; k++) begin
                    offer_request(make_request($urandom_range(0, 3) != 0));
                    sent++;
                end
                if (gaps_on) begin
                    gap = $urandom_range(0, 5);
                    if (gap > 0) begin
                        req_if.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
hdl/nbam_pkg.sv
hdl/nbam_req_if.sv
hdl/nbam_rsp_if.sv
hdl/nbam_cfg.sv
hdl/nand_bank_address_map_top.sv
test/nbam_map_checker.sv
test/tb_nand_bank_address_map_top.sv
